FILE: rtl/core/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII core.
package sitda_pkg;

   localparam int DD_BITS = 4;
   localparam int DIGIT_W = 4;

   localparam logic [DIGIT_W-1:0] DD_LIMIT  = 4'd5;
   localparam logic [DIGIT_W-1:0] DD_ADJUST = 4'd3;

   localparam logic [5:0] CODE_ZERO  = 6'd48;
   localparam logic [5:0] CODE_MINUS = 6'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LOCATE,
      ST_SIGN,
      ST_DIGITS
   } sitda_state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic locate;
      logic emit_sign;
      logic emit_digit;
   } sitda_cmd_type;

   typedef struct packed {
      logic step_done;
      logic negative;
      logic last_digit;
      logic out_free;
   } sitda_sts_type;

endpackage

FILE: rtl/core/sitda_ctrl.sv
// Controller state machine that sequences conversion and character output.
module sitda_ctrl import sitda_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  sitda_sts_type sts,
   output sitda_cmd_type cmd
);

   sitda_state_type state_ff;
   sitda_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (sts.step_done) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            state_in = sts.negative ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (sts.out_free && sts.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
         end
         ST_SIGN: begin
            cmd.emit_sign = sts.out_free;
         end
         ST_DIGITS: begin
            cmd.emit_digit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_valid) |=> state_ff == ST_IDLE)
      else $error("controller left idle without a transfer");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && sts.last_digit) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after the final digit");

   a_sign_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> sts.negative)
      else $error("sign state entered for a non-negative value");

endmodule

FILE: rtl/core/sitda_datapath.sv
// Datapath with the magnitude, the BCD conversion register and the output register.
module sitda_datapath import sitda_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  sitda_cmd_type          cmd,
   output sitda_sts_type          sts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_char_code,
   output logic                   rsp_last
);

   localparam int STEPS = (VALUE_WIDTH + DD_BITS - 1) / DD_BITS;
   localparam int MAG_W = STEPS * DD_BITS;
   localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int BCD_W = NDIG * DIGIT_W;
   localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [5:0]             rsp_char_code_ff, rsp_char_code_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] mag_abs;
   logic [MAG_W-1:0]       dd_mag;
   logic [BCD_W-1:0]       dd_bcd;
   logic [IDX_W-1:0]       msd;
   logic [DIGIT_W-1:0]     cur_digit;
   logic                   out_free;

   assign mag_abs   = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
   assign cur_digit = bcd_ff[idx_ff*DIGIT_W +: DIGIT_W];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      dd_bcd = bcd_ff;
      dd_mag = mag_ff;
      for (int b = 0; b < DD_BITS; b++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (dd_bcd[d*DIGIT_W +: DIGIT_W] >= DD_LIMIT) begin
               dd_bcd[d*DIGIT_W +: DIGIT_W] = dd_bcd[d*DIGIT_W +: DIGIT_W] + DD_ADJUST;
            end
         end
         dd_bcd = {dd_bcd[BCD_W-2:0], dd_mag[MAG_W-1]};
         dd_mag = {dd_mag[MAG_W-2:0], 1'b0};
      end
   end

   always_comb begin
      msd = '0;
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] != '0) begin
            msd = IDX_W'(d);
         end
      end
   end

   always_comb begin
      mag_in           = mag_ff;
      bcd_in           = bcd_ff;
      neg_in           = neg_ff;
      cnt_in           = cnt_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_char_code_in = rsp_char_code_ff;
      rsp_last_in      = rsp_last_ff;
      if (cmd.load) begin
         mag_in = MAG_W'(mag_abs);
         bcd_in = '0;
         neg_in = req_value[VALUE_WIDTH-1];
         cnt_in = CNT_W'(STEPS - 1);
      end
      if (cmd.shift) begin
         mag_in = dd_mag;
         bcd_in = dd_bcd;
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.locate) begin
         idx_in = msd;
      end
      if (cmd.emit_sign) begin
         rsp_valid_in     = 1'b1;
         rsp_char_code_in = CODE_MINUS;
         rsp_last_in      = 1'b0;
      end
      if (cmd.emit_digit) begin
         rsp_valid_in     = 1'b1;
         rsp_char_code_in = CODE_ZERO + {2'b00, cur_digit};
         rsp_last_in      = (idx_ff == '0);
         idx_in           = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      bcd_ff           <= bcd_in;
      neg_ff           <= neg_in;
      cnt_ff           <= cnt_in;
      idx_ff           <= idx_in;
      rsp_char_code_ff <= rsp_char_code_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign sts.step_done  = (cnt_ff == '0);
   assign sts.negative   = neg_ff;
   assign sts.last_digit = (idx_ff == '0);
   assign sts.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> out_free)
      else $error("character written while the output register was occupied");

   a_msd_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.locate |=> (cur_digit != '0 || idx_ff == '0))
      else $error("leading digit located on a zero digit");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> cur_digit <= 4'd9)
      else $error("conversion produced a digit above nine");

endmodule

FILE: rtl/core/signed_int_to_decimal_ascii_core.sv
// Top level of the signed integer to decimal ASCII converter.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_value
//   rsp      out        rsp_valid / rsp_stall  rsp_char_code, rsp_last
//
// The BCD conversion unit takes four magnitude bits per cycle, and the output
// register delivers one character per cycle while rsp is not stalled.
// Reset clears the controller and the output valid; nothing else needs it.
// A stall on rsp holds the current character and pauses the digit sequence.
// req_stall is low only while the block is idle.
module signed_int_to_decimal_ascii_core import sitda_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_char_code,
   output logic                   rsp_last
);

   sitda_cmd_type cmd;
   sitda_sts_type sts;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sitda_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule
